[hdl/robb_pkg.sv]
// Shared types and constants for the ray / oriented box slab test.
// No dependencies; used by robb_div and ray_obb_slab_intersection.
package robb_pkg;

    localparam int COORD_BITS_DEF = 21;  // default width of one register component
    localparam int IN_BITS        = 21;  // origin and direction fields
    localparam int DIST_BITS      = 21;  // Q11.10 distances
    localparam int REG_BITS       = 63;  // one configuration register
    localparam int CFG_IDX_W      = 3;
    localparam int EXT_SHIFT      = 20;  // edge length to doubled half extent scale
    localparam int PRE_SHIFT      = 3;   // numerator bits above the quotient LSB weight
    localparam int DIV_STEPS      = 21;  // quotient bits produced, one per stage
    localparam int DIV_LAT        = DIV_STEPS + 1;
    localparam int Q_W            = DIST_BITS + 2;  // signed, magnitude up to 2^21
    localparam int ACC_W          = 42;  // entry / exit accumulators, hold +-2^40

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER = 3'd0,
        CFG_AXIS_U = 3'd1,
        CFG_AXIS_V = 3'd2,
        CFG_AXIS_W = 3'd3,
        CFG_SIZE   = 3'd4
    } t_cfg_idx;

    // Per-ray flags that ride alongside the divider pipelines.
    typedef struct packed {
        logic [2:0]           par;   // projected direction is zero on this axis
        logic                 mpar;  // some parallel axis has the origin outside
        logic [DIST_BITS-1:0] maxd;
    } t_side;

endpackage

[hdl/robb_div.sv]
// Pipelined signed slab divider: quotient num * 2^18 / den, truncated, saturated at 2^21.
// One restoring step per stage; depends on robb_pkg.
module robb_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [63:0]                i_num,
    input  logic signed [63:0]                i_den,
    output logic signed [robb_pkg::Q_W-1:0]   o_quot
);
    import robb_pkg::*;

    logic [63:0] w_a;
    logic [63:0] w_b;
    logic        w_cap;

    logic [63:0]           r_rem [DIV_LAT];
    logic [63:0]           r_b   [DIV_LAT];
    logic [DIST_BITS-1:0]  r_q   [DIV_LAT];
    logic [PRE_SHIFT-1:0]  r_lo  [DIV_LAT];
    logic                  r_neg [DIV_LAT];
    logic                  r_cap [DIV_LAT];

    assign w_a   = i_num[63] ? 64'(-i_num) : 64'(i_num);
    assign w_b   = i_den[63] ? 64'(-i_den) : 64'(i_den);
    // Quotient reaches 2^21 exactly when a >= 8b.
    assign w_cap = {3'b000, w_a} >= {w_b, 3'b000};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {3'b000, w_a[63:PRE_SHIFT]};
            r_lo[0]  <= w_a[PRE_SHIFT-1:0];
            r_b[0]   <= w_b;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[63] ^ i_den[63];
            r_cap[0] <= w_cap;
        end
    end

    for (genvar s = 1; s < DIV_LAT; s++) begin : g_step
        logic        w_bit;
        logic [64:0] w_trial;
        logic        w_ge;

        if (s <= PRE_SHIFT) begin : g_in
            assign w_bit = r_lo[s-1][PRE_SHIFT-s];
        end else begin : g_zero
            assign w_bit = 1'b0;
        end

        assign w_trial = {r_rem[s-1], w_bit};
        assign w_ge    = w_trial >= {1'b0, r_b[s-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? 64'(w_trial - {1'b0, r_b[s-1]}) : w_trial[63:0];
                r_q[s]   <= {r_q[s-1][DIST_BITS-2:0], w_ge};
                r_lo[s]  <= r_lo[s-1];
                r_b[s]   <= r_b[s-1];
                r_neg[s] <= r_neg[s-1];
                r_cap[s] <= r_cap[s-1];
            end
        end
    end

    logic [Q_W-1:0] w_mag;
    assign w_mag  = r_cap[DIV_LAT-1] ? (Q_W'(1) << DIST_BITS)
                                     : Q_W'(r_q[DIV_LAT-1]);
    assign o_quot = r_neg[DIV_LAT-1] ? $signed(Q_W'(-w_mag)) : $signed(w_mag);

endmodule

[hdl/ray_obb_slab_intersection.sv]
// Top level of the ray / oriented box slab test: configuration registers and main pipeline.
// Depends on robb_pkg and robb_div.
//
// Usage. The box (center, three unit axes, edge lengths) is loaded through the write port
// i_cfg_we / i_cfg_index / i_cfg_wdata while no ray is in flight; indexes past the box
// size register are ignored. Rays arrive as beats on the input channel (i_valid, o_stall)
// and each produces exactly one result beat (o_hit, o_hit_distance) on the output channel
// (o_valid, i_stall), in order.
// Throughput is one ray per cycle while i_stall does not hold the output. The beat passes
// 29 register stages, the first of them loaded at the accepting edge and the last being the
// output register: 4 stages of projection (offset, products, sums, numerators), 22
// stages in the six parallel slab dividers, which resolve one quotient bit per stage, and
// 3 stages of interval narrowing and range check.
// The whole pipeline moves as one: while a result beat is held by i_stall, o_stall is
// raised and every stage keeps its contents, so nothing is lost or repeated; bubbles in
// the pipeline keep moving whenever the output register is empty.
// Reset (synchronous, active low) clears all valid bits and zeroes the box registers.
module ray_obb_slab_intersection #(
    parameter int COORD_BITS = robb_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [robb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [robb_pkg::REG_BITS-1:0]     i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [robb_pkg::IN_BITS-1:0]   i_origin_x,
    input  logic signed [robb_pkg::IN_BITS-1:0]   i_origin_y,
    input  logic signed [robb_pkg::IN_BITS-1:0]   i_origin_z,
    input  logic signed [robb_pkg::IN_BITS-1:0]   i_dir_x,
    input  logic signed [robb_pkg::IN_BITS-1:0]   i_dir_y,
    input  logic signed [robb_pkg::IN_BITS-1:0]   i_dir_z,
    input  logic [robb_pkg::DIST_BITS-1:0]    i_max_distance,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_hit,
    output logic [robb_pkg::DIST_BITS-1:0]    o_hit_distance
);
    import robb_pkg::*;

    localparam int OFF_W  = (COORD_BITS > IN_BITS ? COORD_BITS : IN_BITS) + 1;
    localparam int PA_W   = IN_BITS + COORD_BITS;
    localparam int PC_W   = OFF_W + COORD_BITS;
    localparam int NSTG   = 4 + DIV_LAT + 2;   // S1..S4, divider stages, F1, F2
    localparam logic signed [ACC_W-1:0] ENTRY_INIT = -(ACC_W'(1) <<< 40);
    localparam logic signed [ACC_W-1:0] EXIT_INIT  = ACC_W'(1) <<< 40;

    // Extract component k of a register; components that start at or past bit 64 read zero.
    function automatic logic [COORD_BITS-1:0] f_comp(input logic [REG_BITS-1:0] reg_v,
                                                     input int k);
        logic [63:0] w;
        w = {1'b0, reg_v} >> (k * COORD_BITS);
        return w[COORD_BITS-1:0];
    endfunction

    // Configuration registers.
    logic [REG_BITS-1:0] r_center;
    logic [REG_BITS-1:0] r_axis [3];
    logic [REG_BITS-1:0] r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_axis   <= '{default: '0};
            r_size   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER: r_center  <= i_cfg_wdata;
                CFG_AXIS_U: r_axis[0] <= i_cfg_wdata;
                CFG_AXIS_V: r_axis[1] <= i_cfg_wdata;
                CFG_AXIS_W: r_axis[2] <= i_cfg_wdata;
                CFG_SIZE:   r_size    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic signed [COORD_BITS-1:0] w_center [3];
    logic        [COORD_BITS-1:0] w_size   [3];
    logic signed [COORD_BITS-1:0] w_axis   [3][3];

    for (genvar k = 0; k < 3; k++) begin : g_comp
        assign w_center[k] = $signed(f_comp(r_center, k));
        assign w_size[k]   = f_comp(r_size, k);
        for (genvar i = 0; i < 3; i++) begin : g_ax
            assign w_axis[i][k] = $signed(f_comp(r_axis[i], k));
        end
    end

    // Global advance: the pipeline holds only when a finished beat is stalled.
    logic w_en;
    logic r_out_valid;
    logic r_vld [NSTG];

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '{default: 1'b0};
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int j = 1; j < NSTG; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
            r_out_valid <= r_vld[NSTG-1];
        end
    end

    // S1: offset from origin to box center, direction, range.
    logic signed [IN_BITS-1:0] w_org [3];
    logic signed [IN_BITS-1:0] w_dir [3];
    logic signed [OFF_W-1:0]   r_off [3];
    logic signed [IN_BITS-1:0] r_dir [3];
    logic [DIST_BITS-1:0]      r_maxd1, r_maxd2, r_maxd3;

    assign w_org = '{i_origin_x, i_origin_y, i_origin_z};
    assign w_dir = '{i_dir_x, i_dir_y, i_dir_z};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_off[k] <= OFF_W'(w_center[k]) - OFF_W'(w_org[k]);
                r_dir[k] <= w_dir[k];
            end
            r_maxd1 <= i_max_distance;
        end
    end

    // S2: the eighteen products, reduced modulo 2^64.
    logic signed [PA_W-1:0] w_pa [3][3];
    logic signed [PC_W-1:0] w_pc [3][3];
    logic signed [63:0]     r_pa [3][3];
    logic signed [63:0]     r_pc [3][3];

    for (genvar i = 0; i < 3; i++) begin : g_prod
        for (genvar k = 0; k < 3; k++) begin : g_k
            assign w_pa[i][k] = PA_W'(r_dir[k]) * PA_W'(w_axis[i][k]);
            assign w_pc[i][k] = PC_W'(r_off[k]) * PC_W'(w_axis[i][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pa[i][k] <= 64'(w_pa[i][k]);
                    r_pc[i][k] <= 64'(w_pc[i][k]);
                end
            end
            r_maxd2 <= r_maxd1;
        end
    end

    // S3: projections of the direction and the offset on each box axis.
    logic signed [63:0] r_along [3];
    logic signed [63:0] r_cen   [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_along[i] <= r_pa[i][0] + r_pa[i][1] + r_pa[i][2];
                r_cen[i]   <= r_pc[i][0] + r_pc[i][1] + r_pc[i][2];
            end
            r_maxd3 <= r_maxd2;
        end
    end

    // S4: slab numerators and the containment test for parallel axes.
    logic [63:0]        w_ext2 [3];
    logic [63:0]        w_cen2 [3];
    logic [63:0]        w_mag2 [3];
    logic signed [63:0] r_nn   [3];
    logic signed [63:0] r_nf   [3];
    logic signed [63:0] r_den  [3];
    logic [2:0]         w_par;
    logic [2:0]         w_pout;
    t_side              r_side [DIV_LAT+1];

    for (genvar i = 0; i < 3; i++) begin : g_num
        assign w_ext2[i] = 64'(w_size[i]) << EXT_SHIFT;
        assign w_cen2[i] = 64'(r_cen[i]) << 1;
        assign w_mag2[i] = (r_cen[i][63] ? 64'(-r_cen[i]) : 64'(r_cen[i])) << 1;
        assign w_par[i]  = (r_along[i] == '0);
        assign w_pout[i] = w_mag2[i] > w_ext2[i];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_nn[i]  <= $signed(w_cen2[i] - w_ext2[i]);
                r_nf[i]  <= $signed(w_cen2[i] + w_ext2[i]);
                r_den[i] <= r_along[i];
            end
            r_side[0].par  <= w_par;
            r_side[0].mpar <= |(w_par & w_pout);
            r_side[0].maxd <= r_maxd3;
            for (int j = 1; j <= DIV_LAT; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // Six slab dividers, near and far for each axis.
    logic signed [Q_W-1:0] w_qn [3];
    logic signed [Q_W-1:0] w_qf [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        robb_div u_div_near (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_nn[i]),
            .i_den  (r_den[i]),
            .o_quot (w_qn[i])
        );
        robb_div u_div_far (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_nf[i]),
            .i_den  (r_den[i]),
            .o_quot (w_qf[i])
        );
    end

    // F1: order each slab pair.
    logic signed [Q_W-1:0] r_lo [3];
    logic signed [Q_W-1:0] r_hi [3];
    t_side                 r_f1_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_qn[i] > w_qf[i]) begin
                    r_lo[i] <= w_qf[i];
                    r_hi[i] <= w_qn[i];
                end else begin
                    r_lo[i] <= w_qn[i];
                    r_hi[i] <= w_qf[i];
                end
            end
            r_f1_side <= r_side[DIV_LAT];
        end
    end

    // F2: narrow the entry / exit interval over the axes that are not parallel.
    // Both bounds move monotonically, so an interval that empties at any axis is
    // still empty after the last one.
    logic signed [ACC_W-1:0] w_entry;
    logic signed [ACC_W-1:0] w_exit;
    logic signed [ACC_W-1:0] r_entry;
    logic signed [ACC_W-1:0] r_exit;
    logic                    r_f2_mpar;
    logic [DIST_BITS-1:0]    r_f2_maxd;

    always_comb begin
        w_entry = ENTRY_INIT;
        w_exit  = EXIT_INIT;
        for (int i = 0; i < 3; i++) begin
            if (!r_f1_side.par[i]) begin
                if (ACC_W'(r_lo[i]) > w_entry) begin
                    w_entry = ACC_W'(r_lo[i]);
                end
                if (ACC_W'(r_hi[i]) < w_exit) begin
                    w_exit = ACC_W'(r_hi[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_entry   <= w_entry;
            r_exit    <= w_exit;
            r_f2_mpar <= r_f1_side.mpar;
            r_f2_maxd <= r_f1_side.maxd;
        end
    end

    // F3: pick the entry, or the exit for a ray that starts inside, and range check it.
    logic signed [ACC_W-1:0] w_dist;
    logic                    w_hit;
    logic                    r_out_hit;
    logic [DIST_BITS-1:0]    r_out_dist;

    assign w_dist = (r_entry >= 0) ? r_entry : r_exit;
    assign w_hit  = !r_f2_mpar && (r_entry <= r_exit) && (w_dist >= 0)
                    && (w_dist <= $signed(ACC_W'(r_f2_maxd)));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit  <= w_hit;
            r_out_dist <= w_hit ? w_dist[DIST_BITS-1:0] : '0;
        end
    end

    assign o_hit          = r_out_hit;
    assign o_hit_distance = r_out_dist;

    // A miss always reports a zero distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_hit |-> r_out_dist == '0)
        else $error("miss with nonzero distance");

    // While held, the first and last pipeline valid bits and the output valid bit do not move.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_out_valid) && $stable(r_vld[0]) && $stable(r_vld[NSTG-1]))
        else $error("pipeline moved while stalled");

    // An accepted beat always enters the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted beat not captured");

endmodule
